[hdl/complex_arithmetic_unit_defines.svh]
// Assertion macros for the complex arithmetic unit.
// Used by the top level only; they expand to nothing when SYNTHESIS is defined.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("complex_arithmetic_unit: implication check failed");
`define CAU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("complex_arithmetic_unit: forbidden condition seen");
`else
`define CAU_ASSERT_IMPL(lbl, pre, post)
`define CAU_ASSERT_NEVER(lbl, cond)
`endif
`endif

[hdl/cau_pkg.sv]
// Package for the complex arithmetic unit: payload structs, codes, cell data
// and the saturation helpers. No dependencies.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  // quotient bits produced by the divider chain, one per cell
  localparam int QBITS = 33;
  localparam int NCELLS = QBITS;
  // remainder / shifted divisor width: 64-bit divisor shifted by up to QBITS
  localparam int CW = 64 + QBITS;
  localparam int IDXW = $clog2(QBITS);

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // data handed from cell to cell
  typedef struct packed {
    kind_e             kind;
    logic              dz;
    sat_t              pre_re;
    sat_t              pre_im;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
    logic [CW-1:0]     r_re;
    logic [CW-1:0]     r_im;
    logic [QBITS-1:0]  q_re;
    logic [QBITS-1:0]  q_im;
    logic [63:0]       d;
  } cell_t;

  // saturate a signed 65-bit value to 32 bits
  function automatic sat_t sat_s65(input logic signed [64:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > 65'sd2147483647) begin
      s.ovf = 1'b1;
      s.val = 32'h7FFF_FFFF;
    end else if (v < -65'sd2147483648) begin
      s.ovf = 1'b1;
      s.val = 32'h8000_0000;
    end
    return s;
  endfunction

  // saturate a quotient magnitude with its sign; big means at least 2^QBITS
  function automatic sat_t sat_div(input logic neg, input logic big,
                                   input logic [QBITS-1:0] q);
    sat_t             s;
    logic [QBITS-1:0] qq;
    qq = big ? {1'b1, {(QBITS-1){1'b0}}} : q;
    s.ovf = 1'b0;
    s.val = qq[31:0];
    if (neg && (qq != '0)) begin
      if (qq > QBITS'(33'h0_8000_0000)) begin
        s.ovf = 1'b1;
        s.val = 32'h8000_0000;
      end else begin
        s.val = 32'(-qq);
      end
    end else if (qq > QBITS'(33'h0_7FFF_FFFF)) begin
      s.ovf = 1'b1;
      s.val = 32'h7FFF_FFFF;
    end
    return s;
  endfunction

endpackage

[hdl/complex_arithmetic_unit.sv]
// Complex add/sub/mul/div in signed Q16.16. Every operation passes through
// the same stages: 3 front stages (multipliers, sums, divider setup), 33 divider
// cells (one quotient bit each) and 1 output register.
// Throughput is one transaction per cycle; stall only backs up through full
// stages. Reset clears the stage valid bits; data registers are not reset.
// Depends on cau_pkg, cau_front, cau_cell, cau_back and the defines header.
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic  lv [NCELLS+1];
  logic  ls [NCELLS+1];
  cell_t ld [NCELLS+1];

  cau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (lv[0]),
    .out_stall_i (ls[0]),
    .out_data_o  (ld[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    cau_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (IDXW'(QBITS - 1 - k)),
      .in_valid_i  (lv[k]),
      .in_stall_o  (ls[k]),
      .in_data_i   (ld[k]),
      .out_valid_o (lv[k+1]),
      .out_stall_i (ls[k+1]),
      .out_data_o  (ld[k+1])
    );
  end

  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lv[NCELLS]),
    .in_stall_o  (ls[NCELLS]),
    .in_data_i   (ld[NCELLS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // checks
  `CAU_ASSERT_NEVER(a_stall_source, in_stall_o && !out_stall_i)
  `CAU_ASSERT_IMPL(a_dz_zero, out_valid_o && out_data_o.status == ST_DZ,
    out_data_o.res_re == '0 && out_data_o.res_im == '0)
  `CAU_ASSERT_IMPL(a_ovf_sat, out_valid_o && out_data_o.status == ST_OVF,
    out_data_o.res_re == 32'sh7FFF_FFFF || out_data_o.res_re == 32'sh8000_0000 ||
    out_data_o.res_im == 32'sh7FFF_FFFF || out_data_o.res_im == 32'sh8000_0000)

endmodule

[hdl/cau_front.sv]
// Front end: products, sums and divider setup in three registered stages.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output cell_t out_data_o
);

  logic v1_q, v2_q, v3_q;
  logic st1, st2, st3;

  // stage 1 registers
  kind_e              kind1_q;
  logic signed [31:0] ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;

  // stage 2 registers
  kind_e              kind2_q;
  logic signed [64:0] u_re_q, u_im_q;
  logic [63:0]        d2_q;
  logic signed [32:0] as_re_q, as_im_q;

  logic signed [64:0] u_re_d, u_im_d;
  logic signed [32:0] as_re_d, as_im_d;
  cell_t              c_d, c_q;
  logic [63:0]        mag_re, mag_im;
  logic [CW-1:0]      dlim;

  // stall ripples back only through full stages
  assign st3 = v3_q && out_stall_i;
  assign st2 = v2_q && st3;
  assign st1 = v1_q && st2;
  assign in_stall_o = st1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (!st1) v1_q <= in_valid_i;
      if (!st2) v2_q <= v1_q;
      if (!st3) v3_q <= v2_q;
    end
  end

  // stage 1: six multipliers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !st1) begin
      kind1_q <= in_data_i.kind;
      ar1_q   <= in_data_i.a_re;
      ai1_q   <= in_data_i.a_im;
      br1_q   <= in_data_i.b_re;
      bi1_q   <= in_data_i.b_im;
      p_rr_q  <= in_data_i.a_re * in_data_i.b_re;
      p_ii_q  <= in_data_i.a_im * in_data_i.b_im;
      p_ri_q  <= in_data_i.a_re * in_data_i.b_im;
      p_ir_q  <= in_data_i.a_im * in_data_i.b_re;
      sq_r_q  <= in_data_i.b_re * in_data_i.b_re;
      sq_i_q  <= in_data_i.b_im * in_data_i.b_im;
    end
  end

  // stage 2: combine products per operation
  always_comb begin
    if (kind1_q == KIND_DIV) begin
      u_re_d = 65'(p_rr_q) + 65'(p_ii_q);
      u_im_d = 65'(p_ir_q) - 65'(p_ri_q);
    end else begin
      u_re_d = 65'(p_rr_q) - 65'(p_ii_q);
      u_im_d = 65'(p_ri_q) + 65'(p_ir_q);
    end
    if (kind1_q == KIND_SUB) begin
      as_re_d = 33'(ar1_q) - 33'(br1_q);
      as_im_d = 33'(ai1_q) - 33'(bi1_q);
    end else begin
      as_re_d = 33'(ar1_q) + 33'(br1_q);
      as_im_d = 33'(ai1_q) + 33'(bi1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && !st2) begin
      kind2_q <= kind1_q;
      u_re_q  <= u_re_d;
      u_im_q  <= u_im_d;
      d2_q    <= 64'(sq_r_q) + 64'(sq_i_q);
      as_re_q <= as_re_d;
      as_im_q <= as_im_d;
    end
  end

  // stage 3: direct results and divider setup
  always_comb begin
    c_d        = '0;
    c_d.kind   = kind2_q;
    c_d.d      = d2_q;
    c_d.dz     = (d2_q == '0);
    c_d.neg_re = u_re_q[64];
    c_d.neg_im = u_im_q[64];
    mag_re     = u_re_q[64] ? 64'(-u_re_q) : u_re_q[63:0];
    mag_im     = u_im_q[64] ? 64'(-u_im_q) : u_im_q[63:0];
    c_d.r_re   = CW'(mag_re) << FRAC_BITS;
    c_d.r_im   = CW'(mag_im) << FRAC_BITS;
    dlim       = {d2_q, {QBITS{1'b0}}};
    c_d.big_re = (c_d.r_re >= dlim);
    c_d.big_im = (c_d.r_im >= dlim);
    case (kind2_q)
      KIND_ADD, KIND_SUB: begin
        c_d.pre_re = sat_s65(65'(as_re_q));
        c_d.pre_im = sat_s65(65'(as_im_q));
      end
      KIND_MUL: begin
        c_d.pre_re = sat_s65(u_re_q >>> FRAC_BITS);
        c_d.pre_im = sat_s65(u_im_q >>> FRAC_BITS);
      end
      default: begin
        c_d.pre_re = '0;
        c_d.pre_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && !st3) c_q <= c_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = c_q;

endmodule

[hdl/cau_cell.sv]
// Divider cell: one restoring quotient bit for both parts per transaction.
// Depends on cau_pkg.
module cau_cell import cau_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IDXW-1:0] shift_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cell_t           in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cell_t           out_data_o
);

  logic          v_q;
  cell_t         c_d, c_q;
  logic [CW-1:0] dsh;
  logic          ge_re, ge_im;

  assign in_stall_o = v_q && out_stall_i;

  // compare against the divisor weighted by this cell's bit
  always_comb begin
    c_d   = in_data_i;
    dsh   = CW'(in_data_i.d) << shift_i;
    ge_re = (in_data_i.r_re >= dsh);
    ge_im = (in_data_i.r_im >= dsh);
    if (ge_re) c_d.r_re = in_data_i.r_re - dsh;
    if (ge_im) c_d.r_im = in_data_i.r_im - dsh;
    c_d.q_re = {in_data_i.q_re[QBITS-2:0], ge_re};
    c_d.q_im = {in_data_i.q_im[QBITS-2:0], ge_im};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!in_stall_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) c_q <= c_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = c_q;

endmodule

[hdl/cau_back.sv]
// Output stage: quotient saturation, status and the output register.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  cell_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_data_o
);

  logic v_q;
  out_t o_d, o_q;
  sat_t s_re, s_im;

  assign in_stall_o = v_q && out_stall_i;

  // pick the direct result or the finished quotient; a zero divisor gives zero and ST_DZ
  always_comb begin
    if (in_data_i.kind == KIND_DIV) begin
      s_re = sat_div(in_data_i.neg_re, in_data_i.big_re, in_data_i.q_re);
      s_im = sat_div(in_data_i.neg_im, in_data_i.big_im, in_data_i.q_im);
    end else begin
      s_re = in_data_i.pre_re;
      s_im = in_data_i.pre_im;
    end
    o_d.res_re = s_re.val;
    o_d.res_im = s_im.val;
    o_d.status = (s_re.ovf || s_im.ovf) ? ST_OVF : ST_OK;
    if (in_data_i.kind == KIND_DIV && in_data_i.dz) begin
      o_d.res_re = '0;
      o_d.res_im = '0;
      o_d.status = ST_DZ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!in_stall_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) o_q <= o_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = o_q;

endmodule

[test/complex_arithmetic_unit_tb.sv]
// Self-checking testbench for complex_arithmetic_unit: random and directed
// complex add/sub/mul/div transactions checked against an in-bench predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int LATENCY = 37;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  in_t  pending_ops[$];
  out_t expected_res[$];
  int   mismatch_cnt = 0;
  bit   stim_done = 1'b0;
  bit   hold_sender = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_phase = 0;

  complex_arithmetic_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // saturate a signed value (wide enough for every intermediate) to 32 bits
  function automatic logic [31:0] clamp32(input logic signed [99:0] v, inout bit ovf);
    if (v > 100'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -100'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // truncating division toward zero of num * 2^FRAC_BITS by d
  function automatic logic signed [99:0] trunc_div(input logic signed [99:0] num,
                                                   input logic signed [99:0] d);
    logic signed [99:0] mag;
    logic signed [99:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC_BITS) / d;
    return (num < 0) ? -q : q;
  endfunction

  function automatic out_t complex_result(input in_t op);
    out_t r;
    bit ovf;
    logic signed [99:0] ar, ai, br, bi, pr, pi, d;
    ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
    ovf = 1'b0;
    r = '0;
    case (op.kind)
      KIND_ADD: begin pr = ar + br; pi = ai + bi; end
      KIND_SUB: begin pr = ar - br; pi = ai - bi; end
      KIND_MUL: begin
        pr = (ar * br - ai * bi) >>> FRAC_BITS;
        pi = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      default: begin
        d = br * br + bi * bi;
        pr = 0; pi = 0;
        if (d != 0) begin
          pr = trunc_div(ar * br + ai * bi, d);
          pi = trunc_div(ai * br - ar * bi, d);
        end
      end
    endcase
    if (op.kind == KIND_DIV && d == 0) begin
      r.status = ST_DZ;
      return r;
    end
    r.res_re = clamp32(pr, ovf);
    r.res_im = clamp32(pi, ovf);
    r.status = ovf ? ST_OVF : ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      4: return 32'(int'($urandom_range(0, 512)) - 256);
      5: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(input kind_e k, input logic [31:0] ar, ai, br, bi);
    in_t op;
    op.kind = k; op.a_re = ar; op.a_im = ai; op.b_re = br; op.b_im = bi;
    pending_ops.push_back(op);
  endtask

  // sender: bursts with random gaps, optional hold-off until drained
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_res.push_back(complex_result(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!hold_sender && pending_ops.size() > 0) begin
          in_data_i <= pending_ops.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern and result checking
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_res.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) $display("unexpected result %h", out_data_o);
        end else begin
          exp_r = expected_res.pop_front();
          if (exp_r.res_re !== out_data_o.res_re || exp_r.res_im !== out_data_o.res_im
              || exp_r.status !== out_data_o.status) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                       exp_r.res_re, exp_r.res_im, exp_r.status, out_data_o.res_re,
                       out_data_o.res_im, out_data_o.status);
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase < 20) out_stall_i <= 1'b0;
      else if (stall_phase < 40) out_stall_i <= ($urandom_range(0, 3) == 0);
      else out_stall_i <= ($urandom_range(0, 1) == 0);
    end
  end

  // stimulus
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every operation, zero divisor, overflow corners
    queue_op(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(KIND_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000);
    queue_op(KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_op(KIND_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
    queue_op(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_op(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(KIND_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
    queue_op(KIND_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
    queue_op(KIND_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    queue_op(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
    queue_op(KIND_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
    queue_op(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    queue_op(KIND_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    queue_op(KIND_DIV, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
    queue_op(KIND_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0);
    queue_op(KIND_DIV, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 1800; i++) begin
      queue_op(kind_e'($urandom_range(0, 3)), pick_value(), pick_value(),
               pick_value(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_value());
      if (i == 900) begin
        // drain the pipeline once before continuing
        wait (pending_ops.size() == 0);
        hold_sender = 1'b1;
        @(posedge clk_i);
        wait (expected_res.size() == 0 && !in_valid_i);
        hold_sender = 1'b0;
      end
    end
    wait (pending_ops.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i && expected_res.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    stim_done = 1'b1;
    if (mismatch_cnt == 0 && expected_res.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
